// ===== rtl/core/ktl_pkg.sv =====
package ktl_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_WORD,
    MODE_GT,
    MODE_LT,
    MODE_EQ
  } mode_t;

  // keyword prefix tracking: i, if, a, an, and, o, or
  typedef enum logic [2:0] {
    KW_NONE,
    KW_I,
    KW_IF,
    KW_A,
    KW_AN,
    KW_AND,
    KW_O,
    KW_OR
  } kw_t;

  localparam logic [3:0] KIND_CONST = 4'd0;
  localparam logic [3:0] KIND_IDENT = 4'd1;
  localparam logic [3:0] KIND_IF    = 4'd2;
  localparam logic [3:0] KIND_AND   = 4'd3;
  localparam logic [3:0] KIND_OR    = 4'd4;
  localparam logic [3:0] KIND_GE    = 4'd5;
  localparam logic [3:0] KIND_LE    = 4'd6;
  localparam logic [3:0] KIND_EQ    = 4'd7;
  localparam logic [3:0] KIND_CHAR  = 4'd8;
  localparam logic [3:0] KIND_END   = 4'd9;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_Z    = 8'h5A;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_Z    = 8'h7A;
  localparam logic [7:0] CH_LO_D    = 8'h64;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_LO_I    = 8'h69;
  localparam logic [7:0] CH_LO_N    = 8'h6E;
  localparam logic [7:0] CH_LO_O    = 8'h6F;
  localparam logic [7:0] CH_LO_R    = 8'h72;

  localparam logic [7:0] LEN_MAX = 8'hFF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  ch;
    logic [31:0] val;
    logic        pct;
    logic [7:0]  len;
    logic        ovf;
    logic        last;
  } res_t;

  // results of one scanned item, up to two
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// ===== rtl/core/ktl_scanner.sv =====
module ktl_scanner #(
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [7:0]       ch,
  input  logic             eot,
  output ktl_pkg::push_t   push
);

  localparam int PW = VALUE_BITS + 4;

  ktl_pkg::mode_t          mode, mode_next;
  ktl_pkg::kw_t            kw, kw_next;
  logic [VALUE_BITS-1:0]   acc, acc_next;
  logic                    sat, sat_next;
  logic [7:0]              len, len_next;
  logic                    ended, ended_next;

  logic [PW-1:0]           prod;
  logic                    prod_ovf;
  logic [VALUE_BITS-1:0]   dig_acc;
  logic                    dig_sat;
  logic [7:0]              len_bump;
  logic [63:0]             acc_wide;
  logic [7:0]              lc;
  logic                    is_digit, is_alpha, is_space;
  logic                    is_cmp, is_lone;
  logic                    do_idle;
  ktl_pkg::res_t           r;
  ktl_pkg::kw_t            kw_adv, kw_init;
  logic [3:0]              word_kind;
  logic [3:0]              cmp_kind;

  function automatic ktl_pkg::push_t put(ktl_pkg::push_t p, ktl_pkg::res_t x);
    ktl_pkg::push_t q;
    q = p;
    if (p.n == 2'd0) begin
      q.r0 = x;
    end else begin
      q.r1 = x;
    end
    q.n = p.n + 2'd1;
    return q;
  endfunction

  function automatic ktl_pkg::res_t mk(logic [3:0] kind, logic [7:0] c, logic [31:0] v,
                                       logic pct, logic [7:0] l, logic ovf);
    ktl_pkg::res_t x;
    x.kind = kind;
    x.ch   = c;
    x.val  = v;
    x.pct  = pct;
    x.len  = l;
    x.ovf  = ovf;
    x.last = 1'b0;
    return x;
  endfunction

  assign is_digit = (ch >= ktl_pkg::CH_ZERO) && (ch <= ktl_pkg::CH_NINE);
  assign is_alpha = ((ch >= ktl_pkg::CH_LO_A) && (ch <= ktl_pkg::CH_LO_Z)) ||
                    ((ch >= ktl_pkg::CH_UP_A) && (ch <= ktl_pkg::CH_UP_Z)) ||
                    (ch == ktl_pkg::CH_UNDER);
  assign is_space = (ch == ktl_pkg::CH_SPACE) || (ch == ktl_pkg::CH_TAB) ||
                    (ch == ktl_pkg::CH_LF) || (ch == ktl_pkg::CH_CR);
  assign is_cmp   = (mode == ktl_pkg::MODE_GT) || (mode == ktl_pkg::MODE_LT) ||
                    (mode == ktl_pkg::MODE_EQ);
  assign is_lone  = !is_space && !is_digit && !is_alpha && (ch != ktl_pkg::CH_GT) &&
                    (ch != ktl_pkg::CH_LT) && (ch != ktl_pkg::CH_EQUAL);
  assign lc = ((ch >= ktl_pkg::CH_UP_A) && (ch <= ktl_pkg::CH_UP_Z)) ?
              (ch | 8'h20) : ch;

  // acc * 10 + digit, overflow when any bit above the value width is set
  assign prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + PW'(ch - ktl_pkg::CH_ZERO);
  assign prod_ovf = sat || (prod[PW-1:VALUE_BITS] != '0);
  assign dig_acc  = prod_ovf ? {VALUE_BITS{1'b1}} : prod[VALUE_BITS-1:0];
  assign dig_sat  = prod_ovf;
  assign len_bump = (len == ktl_pkg::LEN_MAX) ? len : len + 8'd1;
  assign acc_wide = 64'(acc);

  always_comb begin
    kw_adv = ktl_pkg::KW_NONE;
    if (kw == ktl_pkg::KW_I && lc == ktl_pkg::CH_LO_F) begin
      kw_adv = ktl_pkg::KW_IF;
    end else if (kw == ktl_pkg::KW_A && lc == ktl_pkg::CH_LO_N) begin
      kw_adv = ktl_pkg::KW_AN;
    end else if (kw == ktl_pkg::KW_AN && lc == ktl_pkg::CH_LO_D) begin
      kw_adv = ktl_pkg::KW_AND;
    end else if (kw == ktl_pkg::KW_O && lc == ktl_pkg::CH_LO_R) begin
      kw_adv = ktl_pkg::KW_OR;
    end
    kw_init = ktl_pkg::KW_NONE;
    if (lc == ktl_pkg::CH_LO_I) begin
      kw_init = ktl_pkg::KW_I;
    end else if (lc == ktl_pkg::CH_LO_A) begin
      kw_init = ktl_pkg::KW_A;
    end else if (lc == ktl_pkg::CH_LO_O) begin
      kw_init = ktl_pkg::KW_O;
    end
    case (kw)
      ktl_pkg::KW_IF:  word_kind = ktl_pkg::KIND_IF;
      ktl_pkg::KW_AND: word_kind = ktl_pkg::KIND_AND;
      ktl_pkg::KW_OR:  word_kind = ktl_pkg::KIND_OR;
      default:         word_kind = ktl_pkg::KIND_IDENT;
    endcase
    case (mode)
      ktl_pkg::MODE_GT: cmp_kind = ktl_pkg::KIND_GE;
      ktl_pkg::MODE_LT: cmp_kind = ktl_pkg::KIND_LE;
      default:          cmp_kind = ktl_pkg::KIND_EQ;
    endcase
  end

  // the character starts a new token once the pending one, if any, is closed
  always_comb begin
    do_idle = 1'b0;
    if (!ended && !eot) begin
      unique case (mode) inside
        ktl_pkg::MODE_NUM:
          do_idle = !is_digit && (ch != ktl_pkg::CH_PERCENT);
        ktl_pkg::MODE_WORD:
          do_idle = !(is_alpha || is_digit);
        ktl_pkg::MODE_GT, ktl_pkg::MODE_LT, ktl_pkg::MODE_EQ:
          do_idle = (ch != ktl_pkg::CH_EQUAL);
        default:
          do_idle = 1'b1;
      endcase
    end
  end

  always_comb begin
    mode_next  = mode;
    kw_next    = kw;
    acc_next   = acc;
    sat_next   = sat;
    len_next   = len;
    ended_next = ended;

    if (!ended && eot) begin
      mode_next  = ktl_pkg::MODE_IDLE;
      ended_next = 1'b1;
    end else if (!ended) begin
      unique case (mode) inside
        ktl_pkg::MODE_NUM: begin
          if (is_digit) begin
            acc_next = dig_acc;
            sat_next = dig_sat;
            len_next = len_bump;
          end else if (ch == ktl_pkg::CH_PERCENT) begin
            len_next  = len_bump;
            mode_next = ktl_pkg::MODE_IDLE;
          end
        end
        ktl_pkg::MODE_WORD: begin
          if (is_alpha || is_digit) begin
            kw_next  = kw_adv;
            len_next = len_bump;
          end
        end
        ktl_pkg::MODE_GT, ktl_pkg::MODE_LT, ktl_pkg::MODE_EQ: begin
          if (ch == ktl_pkg::CH_EQUAL) begin
            mode_next = ktl_pkg::MODE_IDLE;
          end
        end
        default: ;
      endcase

      // scan the character as the start of a new token
      if (do_idle) begin
        mode_next = ktl_pkg::MODE_IDLE;
        if (is_space) begin
          mode_next = ktl_pkg::MODE_IDLE;
        end else if (is_digit) begin
          mode_next = ktl_pkg::MODE_NUM;
          acc_next  = VALUE_BITS'(ch - ktl_pkg::CH_ZERO);
          sat_next  = 1'b0;
          len_next  = 8'd1;
        end else if (is_alpha) begin
          mode_next = ktl_pkg::MODE_WORD;
          len_next  = 8'd1;
          kw_next   = kw_init;
        end else if (ch == ktl_pkg::CH_GT) begin
          mode_next = ktl_pkg::MODE_GT;
        end else if (ch == ktl_pkg::CH_LT) begin
          mode_next = ktl_pkg::MODE_LT;
        end else if (ch == ktl_pkg::CH_EQUAL) begin
          mode_next = ktl_pkg::MODE_EQ;
        end
      end
    end
  end

  always_comb begin
    push = '0;

    // token held by the pending scan state
    unique case (mode)
      ktl_pkg::MODE_NUM:
        r = mk(ktl_pkg::KIND_CONST, 8'd0, acc_wide[31:0], 1'b0, len, sat);
      ktl_pkg::MODE_WORD:
        r = mk(word_kind, 8'd0, 32'd0, 1'b0, len, 1'b0);
      ktl_pkg::MODE_GT:
        r = mk(ktl_pkg::KIND_CHAR, ktl_pkg::CH_GT, 32'd0, 1'b0, 8'd0, 1'b0);
      ktl_pkg::MODE_LT:
        r = mk(ktl_pkg::KIND_CHAR, ktl_pkg::CH_LT, 32'd0, 1'b0, 8'd0, 1'b0);
      ktl_pkg::MODE_EQ:
        r = mk(ktl_pkg::KIND_CHAR, ktl_pkg::CH_EQUAL, 32'd0, 1'b0, 8'd0, 1'b0);
      default:
        r = '0;
    endcase

    if (ended) begin
      push = put(push, mk(ktl_pkg::KIND_END, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0));
    end else if (eot) begin
      // flush the pending token, then close the text
      if (mode != ktl_pkg::MODE_IDLE) begin
        push = put(push, r);
      end
      push = put(push, mk(ktl_pkg::KIND_END, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0));
    end else begin
      if (mode == ktl_pkg::MODE_NUM && ch == ktl_pkg::CH_PERCENT) begin
        push = put(push, mk(ktl_pkg::KIND_CONST, 8'd0, acc_wide[31:0], 1'b1,
                            len_bump, sat));
      end else if (is_cmp && ch == ktl_pkg::CH_EQUAL) begin
        push = put(push, mk(cmp_kind, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0));
      end else if (do_idle && mode != ktl_pkg::MODE_IDLE) begin
        push = put(push, r);
      end
      // a character that is a token by itself
      if (do_idle && is_lone) begin
        push = put(push, mk(ktl_pkg::KIND_CHAR, ch, 32'd0, 1'b0, 8'd0, 1'b0));
      end
    end

    if (push.n == 2'd2) begin
      push.r1.last = 1'b1;
    end else if (push.n == 2'd1) begin
      push.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= ktl_pkg::MODE_IDLE;
      kw    <= ktl_pkg::KW_NONE;
      acc   <= '0;
      sat   <= 1'b0;
      len   <= 8'd0;
      ended <= 1'b0;
    end else if (step) begin
      mode  <= mode_next;
      kw    <= kw_next;
      acc   <= acc_next;
      sat   <= sat_next;
      len   <= len_next;
      ended <= ended_next;
    end
  end

endmodule

// ===== rtl/core/ktl_result_fifo.sv =====
module ktl_result_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  ktl_pkg::push_t  push,
  input  logic            rd_en,
  output ktl_pkg::res_t   head,
  output logic            not_empty,
  output logic            has_room
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  ktl_pkg::res_t   mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count, count_next;
  logic [1:0]      n_in;
  logic [AW-1:0]   wr_ptr1;

  assign n_in      = wr_en ? push.n : 2'd0;
  assign wr_ptr1   = wr_ptr + AW'(1);
  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  // room for the worst case of two results from one item
  assign has_room  = (count <= (AW+1)'(DEPTH - 2));
  assign count_next = count + (AW+1)'(n_in) - (AW+1)'(rd_en);

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (n_in == 2'd2) begin
      mem[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_in);
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count_next;
    end
  end

endmodule

// ===== rtl/core/keyword_token_lexer_unit.sv =====
// A character is registered on transfer and scanned from that input register; its
// results are written into the result queue, from which they are offered.
// Throughput: one character per cycle while the four-entry result queue has room
// for two more results; an item giving two results hands them out one at a time.
// Reset (rst, synchronous, active high) returns the scanner to idle between tokens
// and empties the input register and the result queue.
module keyword_token_lexer_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  token_kind,
  output logic [7:0]  char_value,
  output logic [31:0] int_value,
  output logic        has_percent,
  output logic [7:0]  text_length,
  output logic        overflow,
  output logic        last_of_run
);

  logic            stg_valid;
  logic [7:0]      stg_char;
  logic            stg_eot;
  logic            advance;
  logic            has_room;
  logic            pop;
  ktl_pkg::push_t  push;
  ktl_pkg::res_t   head;

  assign advance  = stg_valid && has_room;
  assign in_stall = stg_valid && !advance;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (!in_stall) begin
      stg_valid <= in_valid;
    end
  end

  // hold the payload while the stage waits for queue room
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      stg_char <= char_code;
      stg_eot  <= end_of_text;
    end
  end

  ktl_scanner #(
    .VALUE_BITS(VALUE_BITS)
  ) u_scanner (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .ch   (stg_char),
    .eot  (stg_eot),
    .push (push)
  );

  ktl_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (advance),
    .push      (push),
    .rd_en     (pop),
    .head      (head),
    .not_empty (out_valid),
    .has_room  (has_room)
  );

  assign token_kind  = head.kind;
  assign char_value  = head.ch;
  assign int_value   = head.val;
  assign has_percent = head.pct;
  assign text_length = head.len;
  assign overflow    = head.ovf;
  assign last_of_run = head.last;

endmodule

// ===== tb/sv/keyword_token_lexer_unit_tb.sv =====
`timescale 1ns / 100ps

module keyword_token_lexer_unit_tb;

  localparam logic [63:0] VALUE_MAX   = 64'h0000_0000_FFFF_FFFF;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          PRINT_LIMIT = 100;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        end_of_text;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [7:0]  char_value;
  logic [31:0] int_value;
  logic        has_percent;
  logic [7:0]  text_length;
  logic        overflow;
  logic        last_of_run;

  keyword_token_lexer_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .end_of_text(end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .char_value(char_value),
    .int_value(int_value),
    .has_percent(has_percent),
    .text_length(text_length),
    .overflow(overflow),
    .last_of_run(last_of_run)
  );

  // scanner state of the predictor
  ktl_pkg::mode_t scan_state;
  logic [63:0]    number_value;
  logic           number_sat;
  logic [7:0]     token_len;
  ktl_pkg::kw_t   kw_state;
  logic           text_done;
  int             item_tokens;

  ktl_pkg::res_t tokens_due[$];

  int  fail_count;
  int  checked_count;
  int  cycle_count;
  int  stall_countdown;
  bit  quiet;
  bit  hold_req;
  bit  hold_seen;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit digit_char(logic [7:0] c);
    return c >= ktl_pkg::CH_ZERO && c <= ktl_pkg::CH_NINE;
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return (c >= ktl_pkg::CH_LO_A && c <= ktl_pkg::CH_LO_Z) ||
           (c >= ktl_pkg::CH_UP_A && c <= ktl_pkg::CH_UP_Z) || c == ktl_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] fold_case(logic [7:0] c);
    return (c >= ktl_pkg::CH_UP_A && c <= ktl_pkg::CH_UP_Z) ? (c | 8'h20) : c;
  endfunction

  task automatic push_token(logic [3:0] kind, logic [7:0] ch, logic [31:0] val, logic pct,
                            logic [7:0] len, logic ovf);
    ktl_pkg::res_t t;
    t.kind = kind;
    t.ch   = ch;
    t.val  = val;
    t.pct  = pct;
    t.len  = len;
    t.ovf  = ovf;
    t.last = 1'b0;
    tokens_due.insert(tokens_due.size(), t);
    item_tokens++;
  endtask

  task automatic bump_len();
    if (token_len != ktl_pkg::LEN_MAX) token_len++;
  endtask

  task automatic add_digit(logic [7:0] c);
    logic [63:0] d;
    d = {56'd0, c - ktl_pkg::CH_ZERO};
    if (number_sat || number_value > (VALUE_MAX - d) / 10) begin
      number_value = VALUE_MAX;
      number_sat = 1'b1;
    end else begin
      number_value = number_value * 10 + d;
    end
    bump_len();
  endtask

  task automatic push_const(logic pct);
    push_token(ktl_pkg::KIND_CONST, 8'd0, number_value[31:0], pct, token_len, number_sat);
  endtask

  task automatic push_word();
    logic [3:0] kind;
    case (kw_state)
      ktl_pkg::KW_IF:  kind = ktl_pkg::KIND_IF;
      ktl_pkg::KW_AND: kind = ktl_pkg::KIND_AND;
      ktl_pkg::KW_OR:  kind = ktl_pkg::KIND_OR;
      default:         kind = ktl_pkg::KIND_IDENT;
    endcase
    push_token(kind, 8'd0, 32'd0, 1'b0, token_len, 1'b0);
  endtask

  task automatic advance_keyword(logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    if (kw_state == ktl_pkg::KW_I && l == ktl_pkg::CH_LO_F) kw_state = ktl_pkg::KW_IF;
    else if (kw_state == ktl_pkg::KW_A && l == ktl_pkg::CH_LO_N) kw_state = ktl_pkg::KW_AN;
    else if (kw_state == ktl_pkg::KW_AN && l == ktl_pkg::CH_LO_D) kw_state = ktl_pkg::KW_AND;
    else if (kw_state == ktl_pkg::KW_O && l == ktl_pkg::CH_LO_R) kw_state = ktl_pkg::KW_OR;
    else kw_state = ktl_pkg::KW_NONE;
  endtask

  // scan a character from the between-tokens state
  task automatic start_token(logic [7:0] c);
    logic [7:0] l;
    l = fold_case(c);
    if (c == ktl_pkg::CH_SPACE || c == ktl_pkg::CH_TAB || c == ktl_pkg::CH_LF ||
        c == ktl_pkg::CH_CR) begin
      // skip blank
    end else if (digit_char(c)) begin
      scan_state = ktl_pkg::MODE_NUM;
      number_value = '0;
      number_sat = 1'b0;
      token_len = '0;
      add_digit(c);
    end else if (letter_char(c)) begin
      scan_state = ktl_pkg::MODE_WORD;
      token_len = 8'd1;
      kw_state = (l == ktl_pkg::CH_LO_I) ? ktl_pkg::KW_I :
                 (l == ktl_pkg::CH_LO_A) ? ktl_pkg::KW_A :
                 (l == ktl_pkg::CH_LO_O) ? ktl_pkg::KW_O : ktl_pkg::KW_NONE;
    end else if (c == ktl_pkg::CH_GT) begin
      scan_state = ktl_pkg::MODE_GT;
    end else if (c == ktl_pkg::CH_LT) begin
      scan_state = ktl_pkg::MODE_LT;
    end else if (c == ktl_pkg::CH_EQUAL) begin
      scan_state = ktl_pkg::MODE_EQ;
    end else begin
      push_token(ktl_pkg::KIND_CHAR, c, 32'd0, 1'b0, 8'd0, 1'b0);
    end
  endtask

  task automatic flush_pending();
    case (scan_state)
      ktl_pkg::MODE_NUM:  push_const(1'b0);
      ktl_pkg::MODE_WORD: push_word();
      ktl_pkg::MODE_GT:   push_token(ktl_pkg::KIND_CHAR, ktl_pkg::CH_GT, 32'd0, 1'b0, 8'd0, 1'b0);
      ktl_pkg::MODE_LT:   push_token(ktl_pkg::KIND_CHAR, ktl_pkg::CH_LT, 32'd0, 1'b0, 8'd0, 1'b0);
      ktl_pkg::MODE_EQ:   push_token(ktl_pkg::KIND_CHAR, ktl_pkg::CH_EQUAL, 32'd0, 1'b0, 8'd0,
                                     1'b0);
      default: ;
    endcase
    scan_state = ktl_pkg::MODE_IDLE;
  endtask

  // work out the tokens one accepted transfer produces
  task automatic lex_char(logic [7:0] c, logic eot);
    item_tokens = 0;
    if (text_done) begin
      push_token(ktl_pkg::KIND_END, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0);
    end else if (eot) begin
      flush_pending();
      push_token(ktl_pkg::KIND_END, 8'd0, 32'd0, 1'b0, 8'd0, 1'b0);
      text_done = 1'b1;
    end else if (scan_state == ktl_pkg::MODE_NUM) begin
      if (digit_char(c)) begin
        add_digit(c);
      end else if (c == ktl_pkg::CH_PERCENT) begin
        bump_len();
        push_const(1'b1);
        scan_state = ktl_pkg::MODE_IDLE;
      end else begin
        push_const(1'b0);
        scan_state = ktl_pkg::MODE_IDLE;
        start_token(c);
      end
    end else if (scan_state == ktl_pkg::MODE_WORD) begin
      if (letter_char(c) || digit_char(c)) begin
        advance_keyword(c);
        bump_len();
      end else begin
        push_word();
        scan_state = ktl_pkg::MODE_IDLE;
        start_token(c);
      end
    end else if (scan_state == ktl_pkg::MODE_GT || scan_state == ktl_pkg::MODE_LT ||
                 scan_state == ktl_pkg::MODE_EQ) begin
      if (c == ktl_pkg::CH_EQUAL) begin
        push_token(scan_state == ktl_pkg::MODE_GT ? ktl_pkg::KIND_GE :
                   scan_state == ktl_pkg::MODE_LT ? ktl_pkg::KIND_LE : ktl_pkg::KIND_EQ,
                   8'd0, 32'd0, 1'b0, 8'd0, 1'b0);
        scan_state = ktl_pkg::MODE_IDLE;
      end else begin
        flush_pending();
        start_token(c);
      end
    end else begin
      start_token(c);
    end
    if (item_tokens > 0) tokens_due[tokens_due.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT)
      $display("ERROR at %0t: token %0d %s: got 0x%0h, expected 0x%0h",
               $time, checked_count, what, got, want);
  endtask

  // one transfer on the input side; entered and left at a falling edge
  task automatic send_item(logic [7:0] c, logic eot);
    if (!quiet && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    char_code = c;
    end_of_text = eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_char(c, eot);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic wait_drain();
    while (tokens_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] word_char(bit first);
    int r;
    r = $urandom_range(first ? 52 : 62);
    if (r < 26) return 8'(ktl_pkg::CH_UP_A + r);
    else if (r < 52) return 8'(ktl_pkg::CH_LO_A + r - 26);
    else if (r == 52) return ktl_pkg::CH_UNDER;
    else return 8'(ktl_pkg::CH_ZERO + r - 53);
  endfunction

  task automatic send_random_token();
    int pick;
    int n;
    string kw;
    logic [7:0] c;
    pick = $urandom_range(99);
    if (pick < 25) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 6);
      repeat (n) send_item(8'(ktl_pkg::CH_ZERO + $urandom_range(9)), 1'b0);
      if ($urandom_range(2) == 0) send_item(ktl_pkg::CH_PERCENT, 1'b0);
    end else if (pick < 50) begin
      case ($urandom_range(3))
        0:       kw = "if";
        1:       kw = "and";
        2:       kw = "or";
        default: kw = "";
      endcase
      if (kw.len() != 0) begin
        // full keyword, a bare prefix of it, or the keyword with a tail
        pick = $urandom_range(2);
        n = (pick == 1) ? kw.len() - 1 : kw.len();
        for (int i = 0; i < n; i++) begin
          c = kw[i];
          if ($urandom_range(1)) c = c & 8'hDF;
          send_item(c, 1'b0);
        end
        if (pick == 2) send_item(word_char(1'b0), 1'b0);
      end else begin
        send_item(word_char(1'b1), 1'b0);
        repeat ($urandom_range(6)) send_item(word_char(1'b0), 1'b0);
      end
    end else if (pick < 62) begin
      case ($urandom_range(2))
        0:       c = ktl_pkg::CH_GT;
        1:       c = ktl_pkg::CH_LT;
        default: c = ktl_pkg::CH_EQUAL;
      endcase
      send_item(c, 1'b0);
      if ($urandom_range(1)) send_item(ktl_pkg::CH_EQUAL, 1'b0);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(3))
          0:       c = ktl_pkg::CH_SPACE;
          1:       c = ktl_pkg::CH_TAB;
          2:       c = ktl_pkg::CH_CR;
          default: c = ktl_pkg::CH_LF;
        endcase
        send_item(c, 1'b0);
      end
    end else begin
      send_item(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // keywords in mixed case, every blank, percent, the two-character operators,
  // lone comparisons, and the lowest and highest codes
  task automatic test_directed_tokens();
    send_text("iF AnD\tOr\r0%\n>=<===>a< =");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("9 ");
  endtask

  task automatic test_value_saturation();
    send_text("4294967295 4294967296 4294967299% 18446744073709551616 ");
    send_text("0000000000004294967295\t");
  endtask

  // a constant longer than the length counter can hold
  task automatic test_length_saturation();
    repeat (257) send_item(8'(ktl_pkg::CH_ZERO + $urandom_range(9)), 1'b0);
    send_item(ktl_pkg::CH_PERCENT, 1'b0);
    send_text(",");
  endtask

  task automatic test_random_text();
    int sent;
    sent = 0;
    quiet = 1'b1;
    while (sent < 60) begin
      if (sent >= 20) quiet = 1'b0;
      send_random_token();
      sent++;
    end
    quiet = 1'b0;
  endtask

  // hold the output off long enough that the block must stall its input
  task automatic test_backpressure();
    @(posedge clk);
    hold_req = ~hold_req;
    @(negedge clk);
    repeat (12) send_random_token();
    wait_drain();
  endtask

  task automatic test_end_of_text();
    send_text(" x oR");
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(ktl_pkg::CH_LO_A, 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(8'hFF, 1'b0);
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    stall_countdown = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        stall_countdown = 60;
      end
      if (stall_countdown > 0) begin
        out_stall = 1'b1;
        stall_countdown--;
      end else begin
        out_stall = !quiet && ($urandom_range(99) < 12);
      end
    end
  end

  always @(posedge clk) begin : token_checker
    ktl_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        report_mismatch("no token due, token_kind", 32'(token_kind), 32'd0);
      end else begin
        want = tokens_due.pop_front();
        if (token_kind !== want.kind)
          report_mismatch("token_kind", 32'(token_kind), 32'(want.kind));
        if (char_value !== want.ch)
          report_mismatch("char_value", 32'(char_value), 32'(want.ch));
        if (int_value !== want.val)
          report_mismatch("int_value", int_value, want.val);
        if (has_percent !== want.pct)
          report_mismatch("has_percent", 32'(has_percent), 32'(want.pct));
        if (text_length !== want.len)
          report_mismatch("text_length", 32'(text_length), 32'(want.len));
        if (overflow !== want.ovf)
          report_mismatch("overflow", 32'(overflow), 32'(want.ovf));
        if (last_of_run !== want.last)
          report_mismatch("last_of_run", 32'(last_of_run), 32'(want.last));
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d tokens outstanding", cycle_count, tokens_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    end_of_text = 1'b0;
    quiet = 1'b0;
    scan_state = ktl_pkg::MODE_IDLE;
    number_value = '0;
    number_sat = 1'b0;
    token_len = '0;
    kw_state = ktl_pkg::KW_NONE;
    text_done = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    test_directed_tokens();
    test_value_saturation();
    test_length_saturation();
    test_random_text();
    test_backpressure();
    test_end_of_text();

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
